[design/bslp_pkg.sv]
// Package for the button short/long press detector.
// Holds the control register indexes, their reset values and widths.
// No dependencies.
package bslp_pkg;

   // Control register port geometry
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // Control register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TIME     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOLDOWN_TIME = 2'd1;

   // Reset values of the control registers
   localparam logic [CSR_DATA_WIDTH-1:0] HOLD_TIME_RESET     = 16'd1000;
   localparam logic [CSR_DATA_WIDTH-1:0] COOLDOWN_TIME_RESET = 16'd200;

endpackage

[design/button_short_long_press.sv]
// Button short/long press detector, top level.
// One tick beat in, one result beat out; uses bslp_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   req     | in        | req_valid/req_stall | req_button_level
//   rsp     | out       | rsp_valid/rsp_stall | rsp_short_press, rsp_long_press
//   csr     | in        | csr_write_en        | csr_index, csr_data
//
// One tick beat is accepted per cycle while req_stall is low; its result appears
// in the next cycle from the result register. The press state is updated at the
// accept edge, so the next tick may follow immediately. req_stall is high only
// while a result is held and the consumer stalls. Reset is synchronous and restores
// the counters, the press state and the hold/cooldown registers to their defaults.
module button_short_long_press #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_button_level,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_short_press,
   output logic                                rsp_long_press,
   // control registers
   input  logic                                csr_write_en,
   input  logic [bslp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bslp_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   // compare width covers both the counters and the 16-bit registers
   localparam int unsigned CMP_WIDTH =
      (COUNT_WIDTH > bslp_pkg::CSR_DATA_WIDTH) ? COUNT_WIDTH : bslp_pkg::CSR_DATA_WIDTH;

   // control registers
   logic [bslp_pkg::CSR_DATA_WIDTH-1:0] hold_time_ff;
   logic [bslp_pkg::CSR_DATA_WIDTH-1:0] cooldown_time_ff;

   // press state
   logic                   pressed_ff,       pressed_in;
   logic                   held_reported_ff, held_reported_in;
   logic [COUNT_WIDTH-1:0] press_elapsed_ff, press_elapsed_in;
   logic [COUNT_WIDTH-1:0] since_short_ff,   since_short_in;

   // result register
   logic rsp_valid_ff,       rsp_valid_in;
   logic rsp_short_press_ff, rsp_short_press_in;
   logic rsp_long_press_ff,  rsp_long_press_in;

   logic                   req_accept;
   logic [COUNT_WIDTH-1:0] since_inc;
   logic [COUNT_WIDTH-1:0] elapsed_inc;

   // saturating counters stop at all ones
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   // accept while the result register is free or being drained
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign since_inc   = sat_inc(since_short_ff);
   assign elapsed_inc = sat_inc(press_elapsed_ff);

   // next press state and result for the tick on the input
   always_comb begin
      pressed_in         = pressed_ff;
      held_reported_in   = held_reported_ff;
      press_elapsed_in   = press_elapsed_ff;
      since_short_in     = since_inc;
      rsp_short_press_in = 1'b0;
      rsp_long_press_in  = 1'b0;
      if (!req_button_level) begin
         // button held: start or extend the press, fire long press once
         pressed_in       = 1'b1;
         press_elapsed_in = pressed_ff ? elapsed_inc : '0;
         if (CMP_WIDTH'(press_elapsed_in) >= CMP_WIDTH'(hold_time_ff) && !held_reported_ff) begin
            rsp_long_press_in = 1'b1;
            held_reported_in  = 1'b1;
         end
      end else if (pressed_ff) begin
         // release edge: qualify a short press
         if (!held_reported_ff &&
             CMP_WIDTH'(elapsed_inc) < CMP_WIDTH'(hold_time_ff) &&
             CMP_WIDTH'(since_inc) >= CMP_WIDTH'(cooldown_time_ff)) begin
            rsp_short_press_in = 1'b1;
            since_short_in     = '0;
         end
         pressed_in       = 1'b0;
         held_reported_in = 1'b0;
         press_elapsed_in = '0;
      end
   end

   // output valid: set on accept, cleared once taken
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   // control registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_time_ff     <= bslp_pkg::HOLD_TIME_RESET;
         cooldown_time_ff <= bslp_pkg::COOLDOWN_TIME_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bslp_pkg::CSR_HOLD_TIME:     hold_time_ff     <= csr_data;
            bslp_pkg::CSR_COOLDOWN_TIME: cooldown_time_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // press state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff       <= 1'b0;
         held_reported_ff <= 1'b0;
         press_elapsed_ff <= '0;
         since_short_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            pressed_ff       <= pressed_in;
            held_reported_ff <= held_reported_in;
            press_elapsed_ff <= press_elapsed_in;
            since_short_ff   <= since_short_in;
         end
      end
   end

   // result payload, loaded per accepted beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_short_press_ff <= rsp_short_press_in;
         rsp_long_press_ff  <= rsp_long_press_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_short_press = rsp_short_press_ff;
   assign rsp_long_press  = rsp_long_press_ff;

endmodule

[design/bslp_checker.sv]
// Port-level checker for the button short/long press detector.
// Sees only the top-level ports; bound to button_short_long_press below.
module bslp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_short_press,
   input logic rsp_long_press
);

   // a result beat never reports both press kinds
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_short_press && rsp_long_press))
      else $error("short and long press in one beat");

   // input stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // an accepted tick always yields a result beat next cycle
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted tick produced no result");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_short_press) && $stable(rsp_long_press)))
      else $error("stalled result changed");

   // no result beat right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind button_short_long_press bslp_checker u_bslp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_short_press (rsp_short_press),
   .rsp_long_press  (rsp_long_press)
);

[test/button_short_long_press_tb.sv]
// Self-checking testbench for the button short/long press detector.
// Drives tick beats and control register writes, predicts both press flags per tick.
// Depends on bslp_pkg and button_short_long_press.
`timescale 1ns / 100ps

module button_short_long_press_tb;

   localparam int unsigned COUNT_WIDTH  = 16;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned IDLE_PERCENT = 9;
   localparam int unsigned PHASE_TICKS  = 200;

   // Indexes with no register behind them; writes there must be ignored
   localparam logic [bslp_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [bslp_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Pin level is active low
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef struct packed {
      logic short_press;
      logic long_press;
   } press_flags_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_button_level = LEVEL_RELEASED;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_short_press;
   logic rsp_long_press;
   logic csr_write_en = 1'b0;
   logic [bslp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = bslp_pkg::CSR_HOLD_TIME;
   logic [bslp_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Idle control for each side
   logic req_idle_en = 1'b1;
   logic rsp_idle_en = 1'b1;

   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   // Predictor state: configuration and press tracking
   logic [bslp_pkg::CSR_DATA_WIDTH-1:0] hold_time_cfg;
   logic [bslp_pkg::CSR_DATA_WIDTH-1:0] cooldown_cfg;
   logic btn_down;
   logic long_reported;
   logic [COUNT_WIDTH-1:0] press_ticks;
   logic [COUNT_WIDTH-1:0] ticks_since_short;

   press_flags_type press_expect[$];

   button_short_long_press #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_button_level(req_button_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_short_press (rsp_short_press),
      .rsp_long_press  (rsp_long_press),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // Advance the press tracker by one tick and return the flags it raises
   function automatic press_flags_type predict_press(input logic level);
      press_flags_type flags;
      logic [COUNT_WIDTH-1:0] hold_len;
      flags = '0;
      ticks_since_short = sat_inc(ticks_since_short);
      if (level == LEVEL_PRESSED) begin
         if (!btn_down) begin
            btn_down = 1'b1;
            press_ticks = '0;
         end else begin
            press_ticks = sat_inc(press_ticks);
         end
         if (press_ticks >= hold_time_cfg && !long_reported) begin
            flags.long_press = 1'b1;
            long_reported = 1'b1;
         end
      end else if (btn_down) begin
         hold_len = sat_inc(press_ticks);
         if (!long_reported && hold_len < hold_time_cfg &&
             ticks_since_short >= cooldown_cfg) begin
            flags.short_press = 1'b1;
            ticks_since_short = '0;
         end
         btn_down = 1'b0;
         long_reported = 1'b0;
         press_ticks = '0;
      end
      return flags;
   endfunction

   // Mirror register writes and tick beats, check result beats
   always @(posedge clock) begin
      press_flags_type want;
      if (reset) begin
         hold_time_cfg = bslp_pkg::HOLD_TIME_RESET;
         cooldown_cfg = bslp_pkg::COOLDOWN_TIME_RESET;
         btn_down = 1'b0;
         long_reported = 1'b0;
         press_ticks = '0;
         ticks_since_short = '0;
         press_expect.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               bslp_pkg::CSR_HOLD_TIME:     hold_time_cfg = csr_data;
               bslp_pkg::CSR_COOLDOWN_TIME: cooldown_cfg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            press_expect.push_back(predict_press(req_button_level));
         if (rsp_valid && !rsp_stall) begin
            if (press_expect.size() == 0) begin
               $display("%0t: result beat with no tick pending, actual short %0b long %0b",
                        $time, rsp_short_press, rsp_long_press);
               fail_count++;
            end else begin
               want = press_expect.pop_front();
               if (rsp_short_press !== want.short_press) begin
                  $display("%0t: short_press expected %0b actual %0b",
                           $time, want.short_press, rsp_short_press);
                  fail_count++;
               end
               if (rsp_long_press !== want.long_press) begin
                  $display("%0t: long_press expected %0b actual %0b",
                           $time, want.long_press, rsp_long_press);
                  fail_count++;
               end
            end
         end
      end
   end

   // Consumer stalls at random
   always @(posedge clock)
      rsp_stall <= rsp_idle_en && ($urandom_range(99, 0) < IDLE_PERCENT);

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Send one tick beat, with an optional random gap ahead of it
   task automatic send_tick(input logic level);
      while (req_idle_en && $urandom_range(99, 0) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_button_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_run(input logic level, input int unsigned n);
      repeat (n) send_tick(level);
   endtask

   // Stop sending and wait until every expected beat has come back
   task automatic quiesce();
      req_valid <= 1'b0;
      // let the last accepted beat reach the queue first
      @(posedge clock);
      while (press_expect.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers; block must be idle
   task automatic program_regs(input logic [bslp_pkg::CSR_DATA_WIDTH-1:0] hold,
                               input logic [bslp_pkg::CSR_DATA_WIDTH-1:0] cool);
      csr_write_en <= 1'b1;
      csr_index <= bslp_pkg::CSR_HOLD_TIME;
      csr_data <= hold;
      @(posedge clock);
      csr_index <= bslp_pkg::CSR_COOLDOWN_TIME;
      csr_data <= cool;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Default registers: release with nothing pressed, early press held off by cooldown
   task automatic test_reset_defaults();
      send_run(LEVEL_RELEASED, 2);
      send_run(LEVEL_PRESSED, 3);
      send_run(LEVEL_RELEASED, 1);
   endtask

   // Zero and tiny hold times, zero cooldown
   task automatic test_zero_hold();
      quiesce();
      program_regs('0, '0);
      send_run(LEVEL_PRESSED, 1);
      send_run(LEVEL_RELEASED, 1);
      send_run(LEVEL_PRESSED, 3);
      send_run(LEVEL_RELEASED, 2);
      quiesce();
      program_regs(16'd2, '0);
      send_run(LEVEL_PRESSED, 1);
      send_run(LEVEL_RELEASED, 1);
      send_run(LEVEL_PRESSED, 1);
      send_run(LEVEL_RELEASED, 1);
      send_run(LEVEL_PRESSED, 2);
      send_run(LEVEL_RELEASED, 1);
      send_run(LEVEL_PRESSED, 3);
      send_run(LEVEL_RELEASED, 1);
   endtask

   // Writes to unmapped indexes must leave both registers alone
   task automatic test_spare_index();
      quiesce();
      program_regs(16'd3, '0);
      csr_write_en <= 1'b1;
      csr_index <= CSR_SPARE_2;
      csr_data <= 16'hFFFF;
      @(posedge clock);
      csr_index <= CSR_SPARE_3;
      csr_data <= 16'h0000;
      @(posedge clock);
      csr_index <= CSR_SPARE_3;
      csr_data <= 16'hFFFF;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      send_run(LEVEL_PRESSED, 4);
      send_run(LEVEL_RELEASED, 1);
      send_run(LEVEL_PRESSED, 2);
      send_run(LEVEL_RELEASED, 1);
   endtask

   // Largest hold and cooldown: no long press fires, cooldown blocks short presses
   task automatic test_max_thresholds();
      quiesce();
      program_regs('1, '1);
      send_run(LEVEL_PRESSED, 40);
      send_run(LEVEL_RELEASED, 1);
      send_run(LEVEL_PRESSED, 2);
      send_run(LEVEL_RELEASED, 1);
      send_run(LEVEL_PRESSED, 2);
      send_run(LEVEL_RELEASED, 1);
   endtask

   // Mostly press/release pairs sized around the thresholds, some noise
   task automatic random_phase(input int unsigned n_ticks,
                               input logic [bslp_pkg::CSR_DATA_WIDTH-1:0] hold,
                               input logic [bslp_pkg::CSR_DATA_WIDTH-1:0] cool);
      int unsigned sent;
      int unsigned run_len;
      int unsigned press_cap;
      int unsigned gap_cap;
      int unsigned back_off;
      quiesce();
      program_regs(hold, cool);
      press_cap = (hold > 40) ? 40 : hold + 3;
      gap_cap = (cool > 40) ? 40 : cool + 4;
      sent = 0;
      while (sent < n_ticks) begin
         if ($urandom_range(99, 0) < 85) begin
            // press length near the hold threshold a quarter of the time
            back_off = $urandom_range(2, 0);
            if (hold <= 40 && $urandom_range(3, 0) == 0)
               run_len = (hold + 1 > back_off) ? hold + 1 - back_off : 1;
            else
               run_len = $urandom_range(press_cap, 1);
            if (run_len == 0) run_len = 1;
            send_run(LEVEL_PRESSED, run_len);
            sent += run_len;
            back_off = $urandom_range(2, 0);
            if (cool <= 40 && $urandom_range(3, 0) == 0)
               run_len = (cool + 1 > back_off) ? cool + 1 - back_off : 1;
            else
               run_len = $urandom_range(gap_cap, 1);
            if (run_len == 0) run_len = 1;
            send_run(LEVEL_RELEASED, run_len);
            sent += run_len;
         end else begin
            repeat ($urandom_range(6, 1)) begin
               send_tick(1'($urandom_range(1, 0)));
               sent++;
            end
         end
      end
   endtask

   task automatic test_random();
      // first phase with no idling on either side
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      random_phase(PHASE_TICKS, bslp_pkg::CSR_DATA_WIDTH'($urandom_range(40, 1)),
                   bslp_pkg::CSR_DATA_WIDTH'($urandom_range(40, 0)));
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      random_phase(PHASE_TICKS, '0, '0);
      random_phase(PHASE_TICKS, '1, '1);
      random_phase(PHASE_TICKS, bslp_pkg::CSR_DATA_WIDTH'($urandom),
                   bslp_pkg::CSR_DATA_WIDTH'($urandom_range(20, 0)));
      repeat (4)
         random_phase(PHASE_TICKS, bslp_pkg::CSR_DATA_WIDTH'($urandom_range(40, 1)),
                      bslp_pkg::CSR_DATA_WIDTH'($urandom_range(60, 0)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_hold();
      test_spare_index();
      test_max_thresholds();
      test_random();
      quiesce();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[button_short_long_press.f]
design/bslp_pkg.sv
design/button_short_long_press.sv
design/bslp_checker.sv
test/button_short_long_press_tb.sv
